// ===== src/smcd_pkg.sv =====
// shared constants, item types and sine table builder for the microstep coil driver
`default_nettype none

package smcd_pkg;

   localparam int unsigned SineSteps       = 1024;
   localparam int unsigned FullScale       = 1024;
   localparam int unsigned PosWidth        = $clog2(SineSteps);
   localparam int unsigned QuarterSteps    = SineSteps / 4;
   localparam int unsigned FullScaleShift  = $clog2(FullScale);
   localparam int unsigned SampleWidth     = 12;
   localparam int unsigned CurrentWidth    = 12;
   localparam int unsigned BiasWidth       = 12;
   localparam int unsigned DeltaWidth      = 16;
   localparam int unsigned CommandWidth    = 2;
   localparam int unsigned MagWidth        = FullScaleShift + 1;
   localparam int unsigned ProdWidth       = MagWidth + CurrentWidth;
   localparam int unsigned MaxCurrentReset = 1024;
   localparam int unsigned HoldCurrent     = (FullScale / 2) * MaxCurrentReset / FullScale;
   localparam int unsigned QueueDepth      = 2;

   // angles in q30 radians
   localparam longint unsigned Q30TwoPi  = 64'd6746518852;
   localparam longint unsigned Q30Pi     = 64'd3373259426;
   localparam longint unsigned Q30HalfPi = 64'd1686629713;
   localparam longint unsigned RomGuard  = 64'd1 << 18;

   typedef enum logic [CommandWidth-1:0] {
      CMD_STEP    = 2'd0,
      CMD_ENABLE  = 2'd1,
      CMD_DISABLE = 2'd2
   } cmd_type;

   typedef struct packed {
      cmd_type               op;
      logic [PosWidth-1:0]   position;
   } item_type;

   typedef logic signed [SampleWidth-1:0] sine_rom_type [SineSteps];

   // fixed-point taylor series, evaluated at elaboration only
   function automatic sine_rom_type build_sine_rom();
      sine_rom_type    rom;
      longint unsigned x;
      longint unsigned x2;
      longint unsigned term;
      longint unsigned sum;
      longint unsigned mag;
      logic            neg;
      for (int i = 0; i < SineSteps; i++) begin
         x   = (longint'(i) * Q30TwoPi) / SineSteps;
         neg = 1'b0;
         if (x > Q30Pi) begin
            neg = 1'b1;
            x   = x - Q30Pi;
         end
         if (x > Q30HalfPi) begin
            x = Q30Pi - x;
         end
         x2   = (x * x) >> 30;
         term = x;
         sum  = x;
         for (int k = 1; k <= 8; k++) begin
            term = (term * x2) >> 30;
            case (k)
               1: begin
                  term = term / 6;
               end
               2: begin
                  term = term / 20;
               end
               3: begin
                  term = term / 42;
               end
               4: begin
                  term = term / 72;
               end
               5: begin
                  term = term / 110;
               end
               6: begin
                  term = term / 156;
               end
               7: begin
                  term = term / 210;
               end
               default: begin
                  term = term / 272;
               end
            endcase
            if ((k % 2) == 1) begin
               sum = (sum > term) ? sum - term : 64'd0;
            end else begin
               sum = sum + term;
            end
         end
         mag = (longint'(FullScale) * sum + RomGuard) >> 30;
         if (mag > longint'(FullScale)) begin
            mag = longint'(FullScale);
         end
         rom[i] = SampleWidth'(mag);
         if (neg) begin
            rom[i] = -rom[i];
         end
      end
      return rom;
   endfunction

endpackage

`default_nettype wire

// ===== src/sine_microstep_coil_driver.sv =====
// top level of the two-phase sine/cosine microstep coil driver
//
//   channel   direction   handshake                  payload
//   req       in          req_valid / req_ready      req_command, req_step_delta
//   rsp       out         rsp_valid / rsp_ready      coil currents, biases, position
//   csr       in          csr_write_en               csr_write_data (peak current)
//
// one command per cycle sustained while rsp_ready holds; each result passes the queue write
// at the transfer, the sine rom read, then the current multiply into the output register
// reset sets position to zero and the peak current to 1024 and empties queue and pipeline
// rsp_ready low fills the output register, the rom stage and then the two-entry queue,
// after which req_ready drops; zero-delta steps and unused codes produce no result
`default_nettype none

module sine_microstep_coil_driver (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   req_valid,
   output logic                                        req_ready,
   input  wire logic [smcd_pkg::CommandWidth-1:0]      req_command,
   input  wire logic signed [smcd_pkg::DeltaWidth-1:0] req_step_delta,
   output logic                                        rsp_valid,
   input  wire logic                                   rsp_ready,
   output logic [smcd_pkg::CurrentWidth-1:0]           rsp_coil_a_current,
   output logic [smcd_pkg::CurrentWidth-1:0]           rsp_coil_b_current,
   output logic [smcd_pkg::BiasWidth-1:0]              rsp_coil_a_bias,
   output logic [smcd_pkg::BiasWidth-1:0]              rsp_coil_b_bias,
   output logic [smcd_pkg::PosWidth-1:0]               rsp_position,
   input  wire logic                                   csr_write_en,
   input  wire logic [smcd_pkg::CurrentWidth-1:0]      csr_write_data
);
   import smcd_pkg::*;

   logic     push_valid;
   logic     push_ready;
   item_type push_item;
   logic     pop_valid;
   logic     pop_ready;
   item_type pop_item;

   smcd_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_command    (req_command),
      .req_step_delta (req_step_delta),
      .push_valid     (push_valid),
      .push_ready     (push_ready),
      .push_item      (push_item)
   );

   smcd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_item   (pop_item)
   );

   smcd_back u_back (
      .clock              (clock),
      .reset              (reset),
      .csr_write_en       (csr_write_en),
      .csr_write_data     (csr_write_data),
      .pop_valid          (pop_valid),
      .pop_ready          (pop_ready),
      .pop_item           (pop_item),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_coil_a_current (rsp_coil_a_current),
      .rsp_coil_b_current (rsp_coil_b_current),
      .rsp_coil_a_bias    (rsp_coil_a_bias),
      .rsp_coil_b_bias    (rsp_coil_b_bias),
      .rsp_position       (rsp_position)
   );

endmodule

`default_nettype wire

// ===== src/smcd_front.sv =====
// front end: takes commands, drops no-ops, tracks the electrical position
`default_nettype none

module smcd_front (
   input  wire logic                                     clock,
   input  wire logic                                     reset,
   input  wire logic                                     req_valid,
   output logic                                          req_ready,
   input  wire logic [smcd_pkg::CommandWidth-1:0]        req_command,
   input  wire logic signed [smcd_pkg::DeltaWidth-1:0]   req_step_delta,
   output logic                                          push_valid,
   input  wire logic                                     push_ready,
   output smcd_pkg::item_type                            push_item
);
   import smcd_pkg::*;

   logic [PosWidth-1:0] position_ff;
   logic [PosWidth-1:0] position_in;
   cmd_type             cmd;
   logic                keep;

   always_comb begin
      cmd         = cmd_type'(req_command);
      position_in = position_ff;
      keep        = 1'b0;
      case (cmd)
         CMD_STEP: begin
            // modulo a power of two: only the low delta bits matter
            keep        = (req_step_delta != '0);
            position_in = position_ff + req_step_delta[PosWidth-1:0];
         end
         CMD_ENABLE, CMD_DISABLE: begin
            keep = 1'b1;
         end
         default: begin
            keep = 1'b0;
         end
      endcase
   end

   assign req_ready  = push_ready;
   assign push_valid = req_valid && keep;
   assign push_item  = '{op: cmd, position: position_in};

   always_ff @(posedge clock) begin
      if (reset) begin
         position_ff <= '0;
      end else if (req_valid && push_ready && keep) begin
         position_ff <= position_in;
      end
   end

endmodule

`default_nettype wire

// ===== src/smcd_queue.sv =====
// small fifo between front and back ends
`default_nettype none

module smcd_queue (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push_valid,
   output logic                    push_ready,
   input  wire smcd_pkg::item_type push_item,
   output logic                    pop_valid,
   input  wire logic               pop_ready,
   output smcd_pkg::item_type      pop_item
);
   import smcd_pkg::*;

   localparam int unsigned PtrWidth   = $clog2(QueueDepth);
   localparam int unsigned CountWidth = $clog2(QueueDepth + 1);

   item_type              entries_ff [QueueDepth];
   logic [PtrWidth-1:0]   wr_ptr_ff;
   logic [PtrWidth-1:0]   rd_ptr_ff;
   logic [CountWidth-1:0] count_ff;
   logic [CountWidth-1:0] count_in;
   logic                  do_push;
   logic                  do_pop;

   assign push_ready = (count_ff != CountWidth'(QueueDepth));
   assign pop_valid  = (count_ff != '0);
   assign pop_item   = entries_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

`default_nettype wire

// ===== src/smcd_back.sv =====
// back end: sine rom lookup, current scaling and the result register
`default_nettype none

module smcd_back (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_write_en,
   input  wire logic [smcd_pkg::CurrentWidth-1:0]   csr_write_data,
   input  wire logic                                pop_valid,
   output logic                                     pop_ready,
   input  wire smcd_pkg::item_type                  pop_item,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic [smcd_pkg::CurrentWidth-1:0]        rsp_coil_a_current,
   output logic [smcd_pkg::CurrentWidth-1:0]        rsp_coil_b_current,
   output logic [smcd_pkg::BiasWidth-1:0]           rsp_coil_a_bias,
   output logic [smcd_pkg::BiasWidth-1:0]           rsp_coil_b_bias,
   output logic [smcd_pkg::PosWidth-1:0]            rsp_position
);
   import smcd_pkg::*;

   localparam sine_rom_type SineRom = build_sine_rom();

   logic                          s1_valid_ff;
   item_type                      s1_item_ff;
   logic signed [SampleWidth-1:0] sin_a_ff;
   logic signed [SampleWidth-1:0] sin_b_ff;
   logic [PosWidth-1:0]           pos_b;

   logic [CurrentWidth-1:0]       peak_current_ff;

   logic                          rsp_valid_ff;
   logic [CurrentWidth-1:0]       cur_a_ff;
   logic [CurrentWidth-1:0]       cur_b_ff;
   logic [BiasWidth-1:0]          bias_a_ff;
   logic [BiasWidth-1:0]          bias_b_ff;
   logic [PosWidth-1:0]           pos_ff;

   logic [CurrentWidth-1:0]       cur_a_in;
   logic [CurrentWidth-1:0]       cur_b_in;
   logic [BiasWidth-1:0]          bias_a_in;
   logic [BiasWidth-1:0]          bias_b_in;
   logic [MagWidth-1:0]           mag_a;
   logic [MagWidth-1:0]           mag_b;
   logic [ProdWidth-1:0]          prod_a;
   logic [ProdWidth-1:0]          prod_b;

   logic                          s1_open;
   logic                          s2_open;

   assign s2_open   = !rsp_valid_ff || rsp_ready;
   assign s1_open   = !s1_valid_ff || s2_open;
   assign pop_ready = s1_open;
   assign pos_b     = pop_item.position + PosWidth'(QuarterSteps);

   // rom read stage
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_open) begin
         s1_valid_ff <= pop_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_open && pop_valid) begin
         s1_item_ff <= pop_item;
         sin_a_ff   <= SineRom[pop_item.position];
         sin_b_ff   <= SineRom[pos_b];
      end
   end

   // scaling stage
   always_comb begin
      mag_a     = MagWidth'(sin_a_ff[SampleWidth-1] ? -sin_a_ff : sin_a_ff);
      mag_b     = MagWidth'(sin_b_ff[SampleWidth-1] ? -sin_b_ff : sin_b_ff);
      prod_a    = ProdWidth'(mag_a) * ProdWidth'(peak_current_ff);
      prod_b    = ProdWidth'(mag_b) * ProdWidth'(peak_current_ff);
      bias_a_in = BiasWidth'($unsigned(sin_a_ff)) + BiasWidth'(FullScale);
      bias_b_in = BiasWidth'($unsigned(sin_b_ff)) + BiasWidth'(FullScale);
      case (s1_item_ff.op)
         CMD_STEP: begin
            cur_a_in = CurrentWidth'(prod_a >> FullScaleShift);
            cur_b_in = CurrentWidth'(prod_b >> FullScaleShift);
         end
         CMD_ENABLE: begin
            cur_a_in = CurrentWidth'(HoldCurrent);
            cur_b_in = CurrentWidth'(HoldCurrent);
         end
         default: begin
            cur_a_in = '0;
            cur_b_in = '0;
         end
      endcase
   end

   // enable reloads the full-scale setting in item order
   always_ff @(posedge clock) begin
      if (reset) begin
         peak_current_ff <= CurrentWidth'(MaxCurrentReset);
      end else if (csr_write_en) begin
         peak_current_ff <= csr_write_data;
      end else if (s2_open && s1_valid_ff && s1_item_ff.op == CMD_ENABLE) begin
         peak_current_ff <= CurrentWidth'(MaxCurrentReset);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s2_open) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_open && s1_valid_ff) begin
         cur_a_ff  <= cur_a_in;
         cur_b_ff  <= cur_b_in;
         bias_a_ff <= bias_a_in;
         bias_b_ff <= bias_b_in;
         pos_ff    <= s1_item_ff.position;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_coil_a_current = cur_a_ff;
   assign rsp_coil_b_current = cur_b_ff;
   assign rsp_coil_a_bias    = bias_a_ff;
   assign rsp_coil_b_bias    = bias_b_ff;
   assign rsp_position       = pos_ff;

endmodule

`default_nettype wire

// ===== tb/smcd_checker.sv =====
// coil drive checker: predicts each result of the microstep driver and compares rsp transfers
`timescale 1ns / 1ps

module smcd_checker (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   input  logic                                   req_ready,
   input  logic [smcd_pkg::CommandWidth-1:0]      req_command,
   input  logic signed [smcd_pkg::DeltaWidth-1:0] req_step_delta,
   input  logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   input  logic [smcd_pkg::CurrentWidth-1:0]      rsp_coil_a_current,
   input  logic [smcd_pkg::CurrentWidth-1:0]      rsp_coil_b_current,
   input  logic [smcd_pkg::BiasWidth-1:0]         rsp_coil_a_bias,
   input  logic [smcd_pkg::BiasWidth-1:0]         rsp_coil_b_bias,
   input  logic [smcd_pkg::PosWidth-1:0]          rsp_position,
   input  logic                                   csr_write_en,
   input  logic [smcd_pkg::CurrentWidth-1:0]      csr_write_data,
   output int                                     mismatch_count,
   output int                                     checked_count,
   output int                                     pending_count
);
   import smcd_pkg::*;

   localparam int Steps        = 1024;
   localparam int Scale        = 1024;
   localparam int CurrentReset = 1024;

   // angles in q30 radians
   localparam longint unsigned TwoPiQ30  = 64'd6746518852;
   localparam longint unsigned PiQ30     = 64'd3373259426;
   localparam longint unsigned HalfPiQ30 = 64'd1686629713;
   localparam longint unsigned RoundQ30  = 64'd262144;

   typedef struct {
      logic [CurrentWidth-1:0] a_current;
      logic [CurrentWidth-1:0] b_current;
      logic [BiasWidth-1:0]    a_bias;
      logic [BiasWidth-1:0]    b_bias;
      logic [PosWidth-1:0]     position;
   } coil_drive_type;

   int                  sine_table [Steps];
   logic [PosWidth-1:0] position;
   int                  peak_current;
   coil_drive_type      pending_drives [$];
   int                  mismatches;
   int                  checked;

   // truncated taylor series up to x^17, folded into the first quadrant
   function automatic int sine_sample(int idx);
      longint unsigned angle;
      longint unsigned sq;
      longint unsigned term;
      longint unsigned acc;
      longint unsigned mag;
      logic            negative;
      angle    = (64'(idx) * TwoPiQ30) / 64'(Steps);
      negative = (angle > PiQ30);
      if (negative) begin
         angle = angle - PiQ30;
      end
      if (angle > HalfPiQ30) begin
         angle = PiQ30 - angle;
      end
      sq   = (angle * angle) >> 30;
      term = angle;
      acc  = angle;
      for (int k = 1; k <= 8; k++) begin
         term = (term * sq) >> 30;
         term = term / 64'((2 * k) * (2 * k + 1));
         if ((k % 2) == 1) begin
            acc = (acc > term) ? acc - term : 64'd0;
         end else begin
            acc = acc + term;
         end
      end
      mag = (64'(Scale) * acc + RoundQ30) >> 30;
      if (mag > 64'(Scale)) begin
         mag = 64'(Scale);
      end
      return negative ? -int'(mag) : int'(mag);
   endfunction

   function automatic logic [CurrentWidth-1:0] coil_level(int sample);
      int magnitude;
      magnitude = (sample < 0) ? -sample : sample;
      return CurrentWidth'((magnitude * peak_current) / Scale);
   endfunction

   function automatic coil_drive_type drive_at(logic [CurrentWidth-1:0] a_cur,
                                               logic [CurrentWidth-1:0] b_cur);
      coil_drive_type d;
      int             pb;
      pb          = (int'(position) + Steps / 4) % Steps;
      d.a_current = a_cur;
      d.b_current = b_cur;
      d.a_bias    = BiasWidth'(sine_table[position] + Scale);
      d.b_bias    = BiasWidth'(sine_table[pb] + Scale);
      d.position  = position;
      return d;
   endfunction

   task automatic apply_command(input logic [CommandWidth-1:0] cmd, input int delta,
                                output bit produces, output coil_drive_type d);
      int step;
      int pb;
      produces = 1'b0;
      case (cmd_type'(cmd))
         CMD_STEP: begin
            if (delta != 0) begin
               step     = delta % Steps;
               position = PosWidth'((int'(position) + step + Steps) % Steps);
               pb       = (int'(position) + Steps / 4) % Steps;
               d        = drive_at(coil_level(sine_table[position]), coil_level(sine_table[pb]));
               produces = 1'b1;
            end
         end
         CMD_ENABLE: begin
            peak_current = CurrentReset;
            d            = drive_at(coil_level(Scale / 2), coil_level(Scale / 2));
            produces     = 1'b1;
         end
         CMD_DISABLE: begin
            d        = drive_at('0, '0);
            produces = 1'b1;
         end
         default: begin
            // unused code leaves everything alone
         end
      endcase
   endtask

   task automatic note_failure(input string msg);
      mismatches++;
      $display("[%0t] MISMATCH: %s", $realtime, msg);
   endtask

   task automatic compare_field(input string name, input int want, input int seen);
      if (want != seen) begin
         note_failure($sformatf("result %0d: %s expected %0d, got %0d",
                                checked, name, want, seen));
      end
   endtask

   initial begin
      for (int i = 0; i < Steps; i++) begin
         sine_table[i] = sine_sample(i);
      end
   end

   always @(posedge clock) begin
      coil_drive_type want;
      coil_drive_type predicted;
      bit             produces;
      if (reset) begin
         position     = '0;
         peak_current = CurrentReset;
         pending_drives.delete();
      end else begin
         if (csr_write_en) begin
            peak_current = int'(csr_write_data);
         end
         if (rsp_valid && rsp_ready) begin
            checked++;
            if (pending_drives.size() == 0) begin
               note_failure($sformatf("result %0d arrived with nothing outstanding", checked));
            end else begin
               want = pending_drives.pop_front();
               compare_field("coil_a_current", int'(want.a_current),
                             int'(rsp_coil_a_current));
               compare_field("coil_b_current", int'(want.b_current),
                             int'(rsp_coil_b_current));
               compare_field("coil_a_bias", int'(want.a_bias), int'(rsp_coil_a_bias));
               compare_field("coil_b_bias", int'(want.b_bias), int'(rsp_coil_b_bias));
               compare_field("position", int'(want.position), int'(rsp_position));
            end
         end
         if (req_valid && req_ready) begin
            apply_command(req_command, int'(req_step_delta), produces, predicted);
            if (produces) begin
               pending_drives.push_back(predicted);
            end
         end
      end
      mismatch_count <= mismatches;
      checked_count  <= checked;
      pending_count  <= pending_drives.size();
   end

endmodule

// ===== tb/tb.sv =====
// testbench top: clock, reset, command and csr stimulus, random stalls and the verdict
`timescale 1ns / 1ps

module tb;
   import smcd_pkg::*;

   localparam logic [CommandWidth-1:0] CmdUnused  = 2'd3;
   localparam int                      CycleLimit = 400000;
   localparam int                      PhaseItems = 300;

   logic                          clock          = 1'b0;
   logic                          reset          = 1'b1;
   logic                          req_valid      = 1'b0;
   logic                          req_ready;
   logic [CommandWidth-1:0]       req_command    = '0;
   logic signed [DeltaWidth-1:0]  req_step_delta = '0;
   logic                          rsp_valid;
   logic                          rsp_ready      = 1'b0;
   logic [CurrentWidth-1:0]       rsp_coil_a_current;
   logic [CurrentWidth-1:0]       rsp_coil_b_current;
   logic [BiasWidth-1:0]          rsp_coil_a_bias;
   logic [BiasWidth-1:0]          rsp_coil_b_bias;
   logic [PosWidth-1:0]           rsp_position;
   logic                          csr_write_en   = 1'b0;
   logic [CurrentWidth-1:0]       csr_write_data = '0;

   int mismatch_count;
   int checked_count;
   int pending_count;

   logic        calm = 1'b0;
   int unsigned rsp_hold;
   int          cycle_count;
   int          steps_sent;
   int          enables_sent;
   int          disables_sent;
   int          ignored_sent;
   int          csr_writes;

   always #5 clock = ~clock;

   sine_microstep_coil_driver u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_command        (req_command),
      .req_step_delta     (req_step_delta),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_coil_a_current (rsp_coil_a_current),
      .rsp_coil_b_current (rsp_coil_b_current),
      .rsp_coil_a_bias    (rsp_coil_a_bias),
      .rsp_coil_b_bias    (rsp_coil_b_bias),
      .rsp_position       (rsp_position),
      .csr_write_en       (csr_write_en),
      .csr_write_data     (csr_write_data)
   );

   smcd_checker u_checker (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_command        (req_command),
      .req_step_delta     (req_step_delta),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_coil_a_current (rsp_coil_a_current),
      .rsp_coil_b_current (rsp_coil_b_current),
      .rsp_coil_a_bias    (rsp_coil_a_bias),
      .rsp_coil_b_bias    (rsp_coil_b_bias),
      .rsp_position       (rsp_position),
      .csr_write_en       (csr_write_en),
      .csr_write_data     (csr_write_data),
      .mismatch_count     (mismatch_count),
      .checked_count      (checked_count),
      .pending_count      (pending_count)
   );

   // receiver stall drawn after every result transfer
   always @(posedge clock) begin
      if (reset) begin
         rsp_hold = 0;
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            rsp_hold = calm ? 0 : $urandom_range(0, 8);
         end
         if (rsp_hold > 0) begin
            rsp_hold--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycle_count, pending_count);
         $display("Verification failed");
         $finish;
      end
   end

   // valid stays high across back-to-back transfers when no gap is drawn
   task automatic send_command(input logic [CommandWidth-1:0] cmd,
                               input logic signed [DeltaWidth-1:0] delta);
      int unsigned gap;
      gap = calm ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_command    <= cmd;
      req_step_delta <= delta;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (cmd == CMD_STEP && delta != 0) begin
         steps_sent++;
      end else if (cmd == CMD_ENABLE) begin
         enables_sent++;
      end else if (cmd == CMD_DISABLE) begin
         disables_sent++;
      end else begin
         ignored_sent++;
      end
   endtask

   // wait for every outstanding result, then let the pipeline run dry
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_peak_current(input logic [CurrentWidth-1:0] level);
      settle();
      csr_write_en   <= 1'b1;
      csr_write_data <= level;
      @(posedge clock);
      csr_write_en   <= 1'b0;
      csr_writes++;
   endtask

   initial begin
      int unsigned             level;
      int unsigned             pick;
      int                      done;
      logic [CommandWidth-1:0] cmd;
      logic signed [DeltaWidth-1:0] delta;

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: wraps, peaks and troughs, delta extremes, every command
      send_command(CMD_STEP, 16'sd1);
      send_command(CMD_STEP, -16'sd1);
      send_command(CMD_STEP, -16'sd1);
      send_command(CMD_STEP, 16'sd0);
      send_command(CMD_STEP, 16'sd257);
      send_command(CMD_STEP, 16'sd512);
      send_command(CMD_STEP, 16'sd32767);
      send_command(CMD_STEP, -16'sd32768);
      send_command(CMD_STEP, 16'sd1024);
      send_command(CMD_ENABLE, 16'sd0);
      send_command(CMD_DISABLE, -16'sd7);
      send_command(CmdUnused, 16'sd5);
      write_peak_current(12'd4095);
      send_command(CMD_STEP, -16'sd511);
      send_command(CMD_STEP, 16'sd512);
      send_command(CMD_DISABLE, 16'sd0);
      write_peak_current(12'd0);
      send_command(CMD_STEP, 16'sd100);
      send_command(CMD_ENABLE, 16'sd0);
      send_command(CMD_STEP, 16'sd3);

      // random phases, each under its own current setting
      for (int ph = 0; ph < 6; ph++) begin
         case (ph)
            0: level = 4095;
            1: level = 0;
            2: level = 1;
            3: level = 2048;
            default: level = $urandom_range(0, 4095);
         endcase
         write_peak_current(CurrentWidth'(level));
         done = 0;
         while (done < PhaseItems) begin
            if ((done % 64) == 0) begin
               calm <= ($urandom_range(0, 3) == 0);
            end
            // enable reloads the peak current, so it stays rare
            pick = $urandom_range(0, 99);
            if (pick < 4) begin
               cmd = CMD_ENABLE;
            end else if (pick < 12) begin
               cmd = CMD_DISABLE;
            end else if (pick < 15) begin
               cmd = CmdUnused;
            end else begin
               cmd = CMD_STEP;
            end
            case ($urandom_range(0, 9))
               0, 1, 2, 3, 4: begin
                  delta = DeltaWidth'(int'($urandom_range(0, 16)) - 8);
               end
               5: begin
                  delta = DeltaWidth'(1024 * (int'($urandom_range(0, 62)) - 31)
                                      + int'($urandom_range(0, 4)) - 2);
               end
               6, 7: begin
                  delta = DeltaWidth'($urandom_range(0, 65535));
               end
               8: begin
                  case ($urandom_range(0, 5))
                     0: delta = 16'sh7fff;
                     1: delta = 16'sh8000;
                     2: delta = 16'sd1023;
                     3: delta = -16'sd1024;
                     4: delta = 16'sd256;
                     default: delta = -16'sd256;
                  endcase
               end
               default: begin
                  delta = DeltaWidth'(int'($urandom_range(0, 2200)) - 1100);
               end
            endcase
            send_command(cmd, delta);
            if (cmd == CMD_ENABLE || cmd == CMD_DISABLE || (cmd == CMD_STEP && delta != 0)) begin
               done++;
            end
         end
      end

      settle();
      $display("sent %0d steps, %0d enables, %0d disables and %0d ignored commands",
               steps_sent, enables_sent, disables_sent, ignored_sent);
      $display("%0d peak current writes, %0d results compared, %0d mismatches",
               csr_writes, checked_count, mismatch_count);
      if (mismatch_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

// ===== files.f =====
src/smcd_pkg.sv
src/smcd_front.sv
src/smcd_queue.sv
src/smcd_back.sv
src/sine_microstep_coil_driver.sv
tb/smcd_checker.sv
tb/tb.sv
